>>> rtl/ivl_pkg.sv
`default_nettype none

package ivl_pkg;

   // Field widths of the request and response transactions
   localparam int OPCODE_W = 3;
   localparam int POS_W    = 6;
   localparam int VALUE_W  = 32;
   localparam int ENTRY_W  = 6;

   // Cell indexes and positions, wide enough for the largest supported depth
   localparam int IDX_W = 7;
   typedef logic [IDX_W-1:0] idx_type;

   // Request opcodes
   localparam logic [OPCODE_W-1:0] OP_APPEND       = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_INSERT       = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_REMOVE_AT    = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_REMOVE_FIRST = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_REMOVE_LAST  = 3'd4;
   localparam logic [OPCODE_W-1:0] OP_DUMP         = 3'd5;

   // Response status codes
   localparam logic STATUS_DONE     = 1'b0;
   localparam logic STATUS_REJECTED = 1'b1;

   // Commands broadcast to the cell row
   localparam logic [1:0] CMD_HOLD   = 2'd0;
   localparam logic [1:0] CMD_INSERT = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;
   localparam logic [1:0] CMD_ROTATE = 2'd3;

   typedef struct packed {
      logic [1:0] cmd;
      idx_type    pos;
      idx_type    wrap;
   } cell_ctl_type;

endpackage

`default_nettype wire

>>> rtl/ivl_channels.sv
`default_nettype none

interface ivl_req_if;
   logic                         valid;
   logic                         ready;
   logic [ivl_pkg::OPCODE_W-1:0] opcode;
   logic [ivl_pkg::POS_W-1:0]    position;
   logic [ivl_pkg::VALUE_W-1:0]  new_value;

   modport source (output valid, output opcode, output position, output new_value,
                   input ready);
   modport sink   (input valid, input opcode, input position, input new_value,
                   output ready);
endinterface

interface ivl_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        status;
   logic [ivl_pkg::ENTRY_W-1:0] entry_count;
   logic [ivl_pkg::VALUE_W-1:0] item_value;
   logic                        item_valid;
   logic                        last_of_run;

   modport source (output valid, output status, output entry_count, output item_value,
                   output item_valid, output last_of_run, input ready);
   modport sink   (input valid, input status, input entry_count, input item_value,
                   input item_valid, input last_of_run, output ready);
endinterface

`default_nettype wire

>>> rtl/indexed_value_list.sv
// Ordered list of up to DEPTH values of VALUE_BITS bits, kept in a row of cells
// that shift up or down together. Append, insert at a position, remove at a
// position, remove first and remove last each finish in the cycle the request
// is accepted and answer with one response (status, new count). A dump gives out
// the stored values in order, one response per cycle while the response side
// keeps up, by rotating the row once through its head cell, and no request is
// taken until the last value is out. Between dumps the block accepts a request
// every cycle as long as the response side keeps up.
`default_nettype none

module indexed_value_list #(
   parameter int DEPTH      = 32,
   parameter int VALUE_BITS = 32
) (
   input  wire        clock,
   input  wire        reset,
   ivl_req_if.sink    req,
   ivl_rsp_if.source  rsp
);

   localparam int CW = $clog2(DEPTH + 1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_DUMP = 1'b1;

   logic                  state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         dump_idx_ff, dump_idx_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  status_ff, status_in;
   logic [ivl_pkg::ENTRY_W-1:0] entry_ff, entry_in;
   logic [ivl_pkg::VALUE_W-1:0] item_ff, item_in;
   logic                  item_valid_ff, item_valid_in;
   logic                  last_ff, last_in;

   logic                  accept, slot_free, full, ok;
   logic [1:0]            edit_cmd;
   ivl_pkg::idx_type      count_x, pos_x, edit_pos;
   ivl_pkg::cell_ctl_type ctl;
   logic [VALUE_BITS-1:0] new_cut;
   logic [VALUE_BITS-1:0] cell_value [DEPTH];

   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == ST_IDLE) && slot_free;
   assign accept    = req.valid && req.ready;

   assign count_x = ivl_pkg::idx_type'(count_ff);
   assign pos_x   = ivl_pkg::idx_type'(req.position);
   assign full    = count_x == ivl_pkg::idx_type'(DEPTH);
   assign new_cut = VALUE_BITS'(req.new_value);

   // Decode the edit and check it against the current count
   always_comb begin
      ok       = 1'b0;
      edit_cmd = ivl_pkg::CMD_HOLD;
      edit_pos = '0;
      case (req.opcode)
         ivl_pkg::OP_APPEND: begin
            ok       = !full;
            edit_cmd = ivl_pkg::CMD_INSERT;
            edit_pos = count_x;
         end
         ivl_pkg::OP_INSERT: begin
            ok       = !full && (pos_x <= count_x);
            edit_cmd = ivl_pkg::CMD_INSERT;
            edit_pos = pos_x;
         end
         ivl_pkg::OP_REMOVE_AT: begin
            ok       = pos_x < count_x;
            edit_cmd = ivl_pkg::CMD_REMOVE;
            edit_pos = pos_x;
         end
         ivl_pkg::OP_REMOVE_FIRST: begin
            ok       = count_x != '0;
            edit_cmd = ivl_pkg::CMD_REMOVE;
            edit_pos = '0;
         end
         ivl_pkg::OP_REMOVE_LAST: begin
            ok       = count_x != '0;
            edit_cmd = ivl_pkg::CMD_REMOVE;
            edit_pos = count_x - ivl_pkg::idx_type'(1);
         end
         default: begin
            ok       = 1'b0;
            edit_cmd = ivl_pkg::CMD_HOLD;
            edit_pos = '0;
         end
      endcase
   end

   // Sequence requests, dumps and the response register
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      dump_idx_in   = dump_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      status_in     = status_ff;
      entry_in      = entry_ff;
      item_in       = item_ff;
      item_valid_in = item_valid_ff;
      last_in       = last_ff;
      ctl.cmd       = ivl_pkg::CMD_HOLD;
      ctl.pos       = edit_pos;
      ctl.wrap      = count_x - ivl_pkg::idx_type'(1);

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req.opcode == ivl_pkg::OP_DUMP) begin
                  if (count_ff == '0) begin
                     rsp_valid_in  = 1'b1;
                     status_in     = ivl_pkg::STATUS_DONE;
                     entry_in      = '0;
                     item_in       = '0;
                     item_valid_in = 1'b0;
                     last_in       = 1'b1;
                  end else begin
                     state_in    = ST_DUMP;
                     dump_idx_in = '0;
                  end
               end else begin
                  if (ok) begin
                     ctl.cmd = edit_cmd;
                     if (edit_cmd == ivl_pkg::CMD_INSERT) begin
                        count_in = count_ff + CW'(1);
                     end else begin
                        count_in = count_ff - CW'(1);
                     end
                  end
                  rsp_valid_in  = 1'b1;
                  status_in     = ok ? ivl_pkg::STATUS_DONE : ivl_pkg::STATUS_REJECTED;
                  entry_in      = ivl_pkg::ENTRY_W'(count_in);
                  item_in       = '0;
                  item_valid_in = 1'b0;
                  last_in       = 1'b1;
               end
            end
         end
         ST_DUMP: begin
            if (slot_free) begin
               ctl.cmd       = ivl_pkg::CMD_ROTATE;
               rsp_valid_in  = 1'b1;
               status_in     = ivl_pkg::STATUS_DONE;
               entry_in      = ivl_pkg::ENTRY_W'(count_ff);
               item_in       = ivl_pkg::VALUE_W'(cell_value[0]);
               item_valid_in = 1'b1;
               last_in       = dump_idx_ff == (count_ff - CW'(1));
               dump_idx_in   = dump_idx_ff + CW'(1);
               if (last_in) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         dump_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dump_idx_ff  <= dump_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload holds without reset
   always_ff @(posedge clock) begin
      status_ff     <= status_in;
      entry_ff      <= entry_in;
      item_ff       <= item_in;
      item_valid_ff <= item_valid_in;
      last_ff       <= last_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = status_ff;
   assign rsp.entry_count = entry_ff;
   assign rsp.item_value  = item_ff;
   assign rsp.item_valid  = item_valid_ff;
   assign rsp.last_of_run = last_ff;

   // Row of cells, each linked to its neighbors
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [VALUE_BITS-1:0] left_v;
      logic [VALUE_BITS-1:0] right_v;

      if (i == 0) begin : g_first
         assign left_v = new_cut;
      end else begin : g_mid_l
         assign left_v = cell_value[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_v = cell_value[i];
      end else begin : g_mid_r
         assign right_v = cell_value[i+1];
      end

      ivl_cell #(
         .VALUE_BITS (VALUE_BITS),
         .INDEX      (i)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .left_value  (left_v),
         .right_value (right_v),
         .new_value   (new_cut),
         .head_value  (cell_value[0]),
         .value_out   (cell_value[i])
      );
   end

endmodule

`default_nettype wire

>>> rtl/ivl_cell.sv
`default_nettype none

module ivl_cell #(
   parameter int VALUE_BITS = 32,
   parameter int INDEX      = 0
) (
   input  wire                        clock,
   input  wire ivl_pkg::cell_ctl_type ctl,
   input  wire [VALUE_BITS-1:0]       left_value,
   input  wire [VALUE_BITS-1:0]       right_value,
   input  wire [VALUE_BITS-1:0]       new_value,
   input  wire [VALUE_BITS-1:0]       head_value,
   output logic [VALUE_BITS-1:0]      value_out
);

   localparam ivl_pkg::idx_type MY_IDX = ivl_pkg::idx_type'(INDEX);

   logic [VALUE_BITS-1:0] value_ff;
   logic [VALUE_BITS-1:0] value_in;

   // Pick this cell's next value: shift up, shift down, take the new value or the head value, or hold
   always_comb begin
      value_in = value_ff;
      case (ctl.cmd)
         ivl_pkg::CMD_INSERT: begin
            if (MY_IDX > ctl.pos) begin
               value_in = left_value;
            end else if (MY_IDX == ctl.pos) begin
               value_in = new_value;
            end
         end
         ivl_pkg::CMD_REMOVE: begin
            if (MY_IDX >= ctl.pos) begin
               value_in = right_value;
            end
         end
         ivl_pkg::CMD_ROTATE: begin
            // the head wraps around to the last occupied cell
            if (MY_IDX == ctl.wrap) begin
               value_in = head_value;
            end else if (MY_IDX < ctl.wrap) begin
               value_in = right_value;
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value_out = value_ff;

endmodule

`default_nettype wire
